/* rtl/core/wbps_pkg.sv */
// Package for the wildcard byte pattern scanner.
// Holds item kinds, character constants, the cell control bundle, the result type and nib_value.
// No dependencies.
package wbps_pkg;

  localparam int unsigned MaxPatternDef = 64;
  localparam int unsigned AddrW         = 64;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_BEGIN = 2'd1,
    KIND_BYTE  = 2'd2
  } kind_e;

  localparam logic [7:0] CharWild  = 8'h3F;  // '?'
  localparam logic [7:0] CharSpace = 8'h20;  // ' '
  localparam logic [7:0] CharA     = 8'h41;  // 'A'
  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CaseMask  = 8'hDF;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic       clear;  // drop the whole pattern
    logic       push;   // shift the row up by one entry, new entry lands in cell 0
    logic       start;  // clear partial matches for a new scan
    logic       step;   // advance partial matches by one memory byte
    logic [7:0] mem;    // memory byte under test
  } cell_ctrl_t;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] addr;
  } result_t;

  // Raw nibble value of a pattern character; non-hex characters are not rejected.
  function automatic logic [7:0] nib_value(input logic [7:0] c);
    logic [7:0] u;
    u = c & CaseMask;
    if (u >= CharA) begin
      return u - CharA + 8'd10;
    end
    return c - CharZero;
  endfunction

endpackage

/* rtl/core/wildcard_byte_pattern_scanner.sv */
// Wildcard byte pattern scanner, top level.
// Parses pattern text into a row of wbps_cell and streams memory bytes through it;
// depends on wbps_pkg, wbps_cell and wbps_out_reg.
//
// One input transfer is taken every clock cycle while the skid stage is empty, pattern
// characters and memory bytes alike; the row of cells updates all partial matches in
// parallel for each byte. The result for a byte leaves through an output register,
// and a skid stage holds a second result while the output is stalled, during which
// the input side is held. Pattern entries are shifted into the row, newest entry in
// cell 0, so a full match always shows at cell 0. Valid bits in the cells clear at
// reset; there is no clearing pass. A match reports the address of the first pattern
// byte; a region that ends without a match, or with an empty pattern, reports not
// found with address zero on its last byte.
module wildcard_byte_pattern_scanner #(
  parameter int unsigned MaxPattern = wbps_pkg::MaxPatternDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // char_or_byte [7:0], base_address [71:8]
  input  logic [1:0]  s_axis_tuser,   // kind [1:0]
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // match_address [63:0]
  output logic        m_axis_tuser    // found [0]
);

  localparam int unsigned LenW = $clog2(MaxPattern + 1);

  logic            accept;
  logic [7:0]      in_char;
  logic [63:0]     in_base;
  wbps_pkg::kind_e kind;

  logic [LenW-1:0] len_q, len_d, eff_len;
  logic            pend_q, pend_d, eff_pend;
  logic            closed_q, closed_d;
  logic            done_q, done_d;
  logic [63:0]     addr_q, addr_d;

  wbps_pkg::cell_ctrl_t ctrl;
  logic                 push_care;
  logic [7:0]           push_pat;
  logic [7:0]           nib;
  logic                 or_low;

  logic              res_valid;
  wbps_pkg::result_t res;
  logic              out_ready;
  wbps_pkg::result_t m_res;

  logic [MaxPattern-1:0] valid_w, care_w, pass_w, hit_w;
  logic [7:0]            pat_w [MaxPattern];

  assign accept  = s_axis_tvalid & s_axis_tready;
  assign in_char = s_axis_tdata[7:0];
  assign in_base = s_axis_tdata[71:8];
  assign kind    = wbps_pkg::kind_e'(s_axis_tuser);
  assign nib     = wbps_pkg::nib_value(in_char);

  // A begin closes the pattern; the next character starts a new one.
  assign eff_len  = closed_q ? '0 : len_q;
  assign eff_pend = closed_q ? 1'b0 : pend_q;

  always_comb begin
    len_d      = len_q;
    pend_d     = pend_q;
    closed_d   = closed_q;
    done_d     = done_q;
    addr_d     = addr_q;
    ctrl       = '0;
    ctrl.mem   = in_char;
    push_care  = 1'b0;
    push_pat   = '0;
    or_low     = 1'b0;
    res_valid  = 1'b0;
    res        = '0;
    if (accept) begin
      unique case (kind)
        wbps_pkg::KIND_CHAR: begin
          if (done_q) begin
            ctrl.clear = closed_q;
            closed_d   = 1'b0;
            len_d      = eff_len;
            pend_d     = 1'b0;
            if (eff_pend) begin
              or_low = (in_char != 8'd0);
            end else if (in_char != wbps_pkg::CharSpace && in_char != 8'd0
                         && eff_len < LenW'(MaxPattern)) begin
              ctrl.push = 1'b1;
              push_care = (in_char != wbps_pkg::CharWild);
              push_pat  = push_care ? {nib[3:0], 4'd0} : 8'd0;
              pend_d    = push_care;
              len_d     = eff_len + LenW'(1);
            end
          end
        end
        wbps_pkg::KIND_BEGIN: begin
          ctrl.start = 1'b1;
          done_d     = 1'b0;
          closed_d   = 1'b1;
          // Address of the first pattern byte when the newest byte is at offset zero.
          addr_d     = in_base - 64'(len_q) + 64'd1;
        end
        wbps_pkg::KIND_BYTE: begin
          if (!done_q) begin
            ctrl.step = 1'b1;
            addr_d    = addr_q + 64'd1;
            if (hit_w[0]) begin
              res_valid = 1'b1;
              res.found = 1'b1;
              res.addr  = addr_q;
              done_d    = 1'b1;
            end else if (s_axis_tlast) begin
              res_valid = 1'b1;
              done_d    = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      pend_q   <= 1'b0;
      closed_q <= 1'b0;
      done_q   <= 1'b1;
    end else begin
      len_q    <= len_d;
      pend_q   <= pend_d;
      closed_q <= closed_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
  end

  for (genvar j = 0; j < MaxPattern; j++) begin : g_cell
    logic       prev_valid;
    logic [7:0] prev_pat;
    logic       prev_care;
    logic       above;
    logic       low_en;

    if (j == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_pat   = push_pat;
      assign prev_care  = push_care;
      assign low_en     = or_low;
    end else begin : g_body
      assign prev_valid = ctrl.clear ? 1'b0 : valid_w[j-1];
      assign prev_pat   = pat_w[j-1];
      assign prev_care  = care_w[j-1];
      assign low_en     = 1'b0;
    end

    if (j == MaxPattern - 1) begin : g_top
      assign above = 1'b1;
    end else begin : g_mid
      assign above = pass_w[j+1];
    end

    wbps_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_valid),
      .prev_pat_i   (prev_pat),
      .prev_care_i  (prev_care),
      .low_en_i     (low_en),
      .low_i        (nib),
      .above_i      (above),
      .valid_o      (valid_w[j]),
      .pat_o        (pat_w[j]),
      .care_o       (care_w[j]),
      .pass_o       (pass_w[j]),
      .hit_o        (hit_w[j])
    );
  end

  wbps_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .m_valid_o   (m_axis_tvalid),
    .m_res_o     (m_res),
    .m_ready_i   (m_axis_tready)
  );

  assign s_axis_tready = out_ready;
  assign m_axis_tdata  = m_res.addr;
  assign m_axis_tuser  = m_res.found;

`ifndef NO_ASSERTIONS
  // Results come only from an active scan, and end it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!done_q ##1 done_q))
    else $error("result outside an active scan");
  // A pending low nibble always has an entry to land in.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !closed_q) |-> (len_q != '0 && valid_w[0]))
    else $error("pending nibble without an entry");
  // The pattern length never exceeds the row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MaxPattern))
    else $error("pattern length beyond row size");
  // Cell 0 holds an entry exactly when the open pattern is not empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_w[0] == (len_q != '0)) || closed_q)
    else $error("head cell disagrees with pattern length");
`endif

endmodule

/* rtl/core/wbps_cell.sv */
// One pattern cell: a pattern byte, its care bit, a valid bit and one partial-match bit.
// Entries shift up the row as the pattern grows; depends on wbps_pkg.
module wbps_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wbps_pkg::cell_ctrl_t ctrl_i,
  input  logic                prev_valid_i,
  input  logic [7:0]          prev_pat_i,
  input  logic                prev_care_i,
  input  logic                low_en_i,
  input  logic [7:0]          low_i,
  input  logic                above_i,
  output logic                valid_o,
  output logic [7:0]          pat_o,
  output logic                care_o,
  output logic                pass_o,
  output logic                hit_o
);

  logic       valid_q, valid_d;
  logic [7:0] pat_q, pat_d;
  logic       care_q, care_d;
  logic       pm_q, pm_d;
  logic       eq;

  assign eq   = !care_q || (pat_q == ctrl_i.mem);
  assign pm_d = above_i & eq;

  always_comb begin
    valid_d = valid_q;
    pat_d   = pat_q;
    care_d  = care_q;
    if (ctrl_i.push) begin
      valid_d = prev_valid_i;
      pat_d   = prev_pat_i;
      care_d  = prev_care_i;
    end else if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (low_en_i) begin
      pat_d = pat_q | low_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pm_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.start) begin
        pm_q <= 1'b0;
      end else if (ctrl_i.step) begin
        pm_q <= pm_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q  <= pat_d;
    care_q <= care_d;
  end

  assign valid_o = valid_q;
  assign pat_o   = pat_q;
  assign care_o  = care_q;
  // An empty cell passes a match through, so the oldest entry always sees a start.
  assign pass_o  = valid_q ? pm_q : 1'b1;
  assign hit_o   = valid_q & pm_d;

endmodule

/* rtl/core/wbps_out_reg.sv */
// Output register with a one-entry skid stage for the scanner's results.
// Depends on wbps_pkg for the result type.
module wbps_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  wbps_pkg::result_t res_i,
  output logic              ready_o,
  output logic              m_valid_o,
  output wbps_pkg::result_t m_res_o,
  input  logic              m_ready_i
);

  logic              out_valid_q;
  wbps_pkg::result_t out_q;
  logic              skid_valid_q;
  wbps_pkg::result_t skid_q;
  logic              drain;

  assign drain   = out_valid_q & m_ready_i;
  assign ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (res_valid_i) begin
        if (!out_valid_q || drain) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (drain) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      if (!out_valid_q || drain) begin
        out_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end else if (drain && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_res_o   = out_q;

`ifndef NO_ASSERTIONS
  // A new result never arrives while the skid stage is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !res_valid_i)
    else $error("result arrived with skid stage full");
  // The skid stage is only filled behind a held output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds data with empty output");
  // A stalled output keeps its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");
`endif

endmodule
